// File: hw/rtl/sorted_key_table_with_argmax_top_defines.svh
// Assertion helpers for the checker file.
`ifndef SORTED_KEY_TABLE_WITH_ARGMAX_TOP_DEFINES_SVH
`define SORTED_KEY_TABLE_WITH_ARGMAX_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define SKT_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SKT_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: hw/rtl/skt_pkg.sv
`timescale 1ns / 1ps
package skt_pkg;

    localparam int KEY_W   = 27;
    localparam int GRADE_W = 10;
    localparam int POS_W   = 7;
    localparam int CNT_W   = 7;
    localparam int STAT_W  = 3;
    localparam int REC_W   = GRADE_W + 1 + KEY_W;
    localparam int DATA_W  = 48;

    localparam logic [GRADE_W-1:0] GRADE_TOP = 10'd1000;

    // Operation codes
    localparam logic [2:0] OP_INSERT  = 3'd0;
    localparam logic [2:0] OP_DELETE  = 3'd1;
    localparam logic [2:0] OP_UPDATE  = 3'd2;
    localparam logic [2:0] OP_REPLACE = 3'd3;
    localparam logic [2:0] OP_FIND    = 3'd4;
    localparam logic [2:0] OP_READ    = 3'd5;
    localparam logic [2:0] OP_MAX     = 3'd6;
    localparam logic [2:0] OP_SIZE    = 3'd7;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STAT_W-1:0] ST_BAD_INDEX = 3'd3;
    localparam logic [STAT_W-1:0] ST_NO_GRADED = 3'd4;
    localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_WRITE_NEW,
        S_BEST_RD,
        S_BEST_CMP,
        S_FETCH_RD,
        S_FETCH_TAKE,
        S_FINISH
    } state_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_SCAN_RD,
        CMD_SCAN_CMP,
        CMD_PLAN,
        CMD_SHIFT_RD,
        CMD_SHIFT_WR,
        CMD_WRITE_NEW,
        CMD_BEST_INIT,
        CMD_BEST_RD,
        CMD_BEST_CMP,
        CMD_FETCH_RD,
        CMD_FETCH_TAKE,
        CMD_PUBLISH
    } cmd_t;

    typedef struct packed {
        logic idx_end;
        logic plan_modify;
        logic plan_fetch;
        logic shift_done;
        logic write_new;
        logic out_free;
    } dp_status_t;

endpackage

// File: hw/rtl/skt_ram.sv
`timescale 1ns / 1ps
module skt_ram #(
    parameter int WIDTH = 38,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hw/rtl/skt_ctrl.sv
`timescale 1ns / 1ps
module skt_ctrl
    import skt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t st,
    output cmd_t       cmd
);

    state_t state_reg, state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance sequence
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:       if (in_valid) state_next = S_SCAN_RD;
            S_SCAN_RD:
            begin
                if (!st.idx_end)          state_next = S_SCAN_CMP;
                else if (st.plan_modify)  state_next = S_SHIFT_RD;
                else if (st.plan_fetch)   state_next = S_FETCH_RD;
                else                      state_next = S_FINISH;
            end
            S_SCAN_CMP:   state_next = S_SCAN_RD;
            S_SHIFT_RD:
            begin
                if (!st.shift_done)     state_next = S_SHIFT_WR;
                else if (st.write_new)  state_next = S_WRITE_NEW;
                else                    state_next = S_BEST_RD;
            end
            S_SHIFT_WR:   state_next = S_SHIFT_RD;
            S_WRITE_NEW:  state_next = S_BEST_RD;
            S_BEST_RD:    state_next = st.idx_end ? S_FINISH : S_BEST_CMP;
            S_BEST_CMP:   state_next = S_BEST_RD;
            S_FETCH_RD:   state_next = S_FETCH_TAKE;
            S_FETCH_TAKE: state_next = S_FINISH;
            S_FINISH:     if (st.out_free) state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
    end

    // Drive datapath commands
    always_comb
    begin
        cmd      = CMD_NONE;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) cmd = CMD_LOAD;
            end
            S_SCAN_RD:    cmd = st.idx_end ? CMD_PLAN : CMD_SCAN_RD;
            S_SCAN_CMP:   cmd = CMD_SCAN_CMP;
            S_SHIFT_RD:
            begin
                if (!st.shift_done)     cmd = CMD_SHIFT_RD;
                else if (!st.write_new) cmd = CMD_BEST_INIT;
            end
            S_SHIFT_WR:   cmd = CMD_SHIFT_WR;
            S_WRITE_NEW:  cmd = CMD_WRITE_NEW;
            S_BEST_RD:    if (!st.idx_end) cmd = CMD_BEST_RD;
            S_BEST_CMP:   cmd = CMD_BEST_CMP;
            S_FETCH_RD:   cmd = CMD_FETCH_RD;
            S_FETCH_TAKE: cmd = CMD_FETCH_TAKE;
            S_FINISH:     if (st.out_free) cmd = CMD_PUBLISH;
            default:      cmd = CMD_NONE;
        endcase
    end

endmodule

// File: hw/rtl/skt_datapath.sv
`timescale 1ns / 1ps
module skt_datapath
    import skt_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output dp_status_t        st,
    input  logic [DATA_W-1:0] in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    // Captured operation
    logic [2:0]         op_reg;
    logic [KEY_W-1:0]   key_reg;
    logic               hg_reg;
    logic [GRADE_W-1:0] gr_reg;
    logic [POS_W-1:0]   pos_reg;

    // Table bookkeeping
    logic [CW-1:0]      fill_reg, idx_reg, less_reg;
    logic               found_reg;
    logic [AW-1:0]      at_reg;
    logic               best_valid_reg;
    logic [AW-1:0]      best_pos_reg;
    logic [GRADE_W-1:0] best_gr_reg;

    // Move plan
    logic [AW-1:0]      dst_reg, stop_reg, faddr_reg;
    logic               up_reg, newrec_reg;

    // Working and published result
    logic [STAT_W-1:0]  res_status_reg, o_status_reg;
    logic [KEY_W-1:0]   res_key_reg, o_key_reg;
    logic               res_hg_reg, o_hg_reg;
    logic [GRADE_W-1:0] res_gr_reg, o_gr_reg;
    logic [CNT_W-1:0]   o_count_reg;
    logic               out_valid_reg;

    // RAM ports
    logic               wr_en, rd_en;
    logic [AW-1:0]      wr_addr, rd_addr, src_addr;
    logic [REC_W-1:0]   wr_data, rd_data;
    logic [KEY_W-1:0]   rd_key;
    logic               rd_hg;
    logic [GRADE_W-1:0] rd_gr;

    // Plan
    logic [STAT_W-1:0]  p_status;
    logic               p_modify, p_fetch, p_up, p_newrec;
    logic [AW-1:0]      p_dst, p_stop, p_faddr;
    logic [CW-1:0]      p_fill;
    logic [XW-1:0]      fill_x, pos_x, pm1_x, less_x, at_x, idx_x;
    logic               pos_ok;
    logic [GRADE_W-1:0] in_gr_sat;

    skt_ram #(
        .WIDTH (REC_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_key = rd_data[KEY_W-1:0];
    assign rd_hg  = rd_data[KEY_W];
    assign rd_gr  = rd_data[REC_W-1:KEY_W+1];

    assign fill_x = XW'(fill_reg);
    assign pos_x  = XW'(pos_reg);
    assign pm1_x  = pos_x - XW'(1);
    assign less_x = XW'(less_reg);
    assign at_x   = XW'(at_reg);
    assign idx_x  = XW'(idx_reg);
    assign pos_ok = (pos_x != '0) && (pos_x <= fill_x);

    assign src_addr = up_reg ? (dst_reg - AW'(1)) : (dst_reg + AW'(1));

    // Saturate incoming grade, zero it when no grade is given
    always_comb
    begin
        in_gr_sat = in_data[40:31];
        if (in_gr_sat > GRADE_TOP) in_gr_sat = GRADE_TOP;
        if (!in_data[30]) in_gr_sat = '0;
    end

    // Decide the operation's outcome after the scan
    always_comb
    begin
        p_status = ST_OK;
        p_modify = 1'b0;
        p_fetch  = 1'b0;
        p_up     = 1'b0;
        p_newrec = 1'b0;
        p_dst    = '0;
        p_stop   = '0;
        p_faddr  = '0;
        p_fill   = fill_reg;
        unique case (op_reg)
            OP_INSERT:
            begin
                if (fill_reg >= CW'(CAPACITY)) p_status = ST_FULL;
                else if (found_reg)            p_status = ST_DUPLICATE;
                else
                begin
                    p_modify = 1'b1;
                    p_up     = 1'b1;
                    p_newrec = 1'b1;
                    p_dst    = AW'(fill_reg);
                    p_stop   = AW'(less_reg);
                    p_fill   = fill_reg + CW'(1);
                end
            end
            OP_DELETE:
            begin
                if (!found_reg) p_status = ST_NOT_FOUND;
                else
                begin
                    p_modify = 1'b1;
                    p_dst    = at_reg;
                    p_stop   = AW'(fill_reg - CW'(1));
                    p_fill   = fill_reg - CW'(1);
                end
            end
            OP_UPDATE:
            begin
                if (!found_reg) p_status = ST_NOT_FOUND;
                else
                begin
                    p_modify = 1'b1;
                    p_newrec = 1'b1;
                    p_dst    = at_reg;
                    p_stop   = at_reg;
                end
            end
            OP_REPLACE:
            begin
                if (!pos_ok)                             p_status = ST_BAD_INDEX;
                else if (found_reg && (at_x != pm1_x))   p_status = ST_DUPLICATE;
                else
                begin
                    p_modify = 1'b1;
                    p_newrec = 1'b1;
                    p_dst    = AW'(pm1_x);
                    p_stop   = AW'(less_reg);
                    p_up     = less_x < pm1_x;
                end
            end
            OP_FIND:
            begin
                if (!found_reg) p_status = ST_NOT_FOUND;
                else
                begin
                    p_fetch = 1'b1;
                    p_faddr = at_reg;
                end
            end
            OP_READ:
            begin
                if (!pos_ok) p_status = ST_BAD_INDEX;
                else
                begin
                    p_fetch = 1'b1;
                    p_faddr = AW'(pm1_x);
                end
            end
            OP_MAX:
            begin
                if (!best_valid_reg) p_status = ST_NO_GRADED;
                else
                begin
                    p_fetch = 1'b1;
                    p_faddr = best_pos_reg;
                end
            end
            OP_SIZE:  p_status = ST_OK;
            default:  p_status = ST_OK;
        endcase
    end

    // Select RAM access for the current command
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = dst_reg;
        wr_data = rd_data;
        unique case (cmd)
            CMD_SCAN_RD, CMD_BEST_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = AW'(idx_reg);
            end
            CMD_SHIFT_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = src_addr;
            end
            CMD_FETCH_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = faddr_reg;
            end
            CMD_SHIFT_WR:
            begin
                wr_en = 1'b1;
            end
            CMD_WRITE_NEW:
            begin
                wr_en   = 1'b1;
                wr_addr = stop_reg;
                wr_data = {gr_reg, hg_reg, key_reg};
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg       <= '0;
            best_valid_reg <= 1'b0;
            best_pos_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd == CMD_PLAN) fill_reg <= p_fill;
            if (cmd == CMD_WRITE_NEW || cmd == CMD_BEST_INIT)
            begin
                best_valid_reg <= 1'b0;
                best_pos_reg   <= '0;
            end
            else if (cmd == CMD_BEST_CMP && rd_hg && (!best_valid_reg || rd_gr > best_gr_reg))
            begin
                best_valid_reg <= 1'b1;
                best_pos_reg   <= AW'(idx_reg);
            end
            if (cmd == CMD_PUBLISH)   out_valid_reg <= 1'b1;
            else if (out_ready)       out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        unique case (cmd)
            CMD_LOAD:
            begin
                op_reg      <= in_data[2:0];
                key_reg     <= in_data[29:3];
                hg_reg      <= in_data[30];
                gr_reg      <= in_gr_sat;
                pos_reg     <= in_data[47:41];
                idx_reg     <= '0;
                less_reg    <= '0;
                found_reg   <= 1'b0;
                at_reg      <= '0;
                res_key_reg <= '0;
                res_hg_reg  <= 1'b0;
                res_gr_reg  <= '0;
            end
            CMD_SCAN_CMP:
            begin
                if (rd_key == key_reg)
                begin
                    found_reg <= 1'b1;
                    at_reg    <= AW'(idx_reg);
                end
                // in a replace, the record being overwritten does not count
                if (rd_key < key_reg && !(op_reg == OP_REPLACE && idx_x == pm1_x))
                    less_reg <= less_reg + CW'(1);
                idx_reg <= idx_reg + CW'(1);
            end
            CMD_PLAN:
            begin
                res_status_reg <= p_status;
                dst_reg        <= p_dst;
                stop_reg       <= p_stop;
                up_reg         <= p_up;
                newrec_reg     <= p_newrec;
                faddr_reg      <= p_faddr;
            end
            CMD_SHIFT_WR:
            begin
                dst_reg <= src_addr;
            end
            CMD_WRITE_NEW, CMD_BEST_INIT:
            begin
                idx_reg <= '0;
            end
            CMD_BEST_CMP:
            begin
                if (rd_hg && (!best_valid_reg || rd_gr > best_gr_reg))
                    best_gr_reg <= rd_gr;
                idx_reg <= idx_reg + CW'(1);
            end
            CMD_FETCH_TAKE:
            begin
                res_key_reg <= rd_key;
                res_hg_reg  <= rd_hg;
                res_gr_reg  <= rd_gr;
            end
            CMD_PUBLISH:
            begin
                o_status_reg <= res_status_reg;
                o_key_reg    <= res_key_reg;
                o_hg_reg     <= res_hg_reg;
                o_gr_reg     <= res_gr_reg;
                o_count_reg  <= CNT_W'(fill_reg);
            end
            default:
            begin
                idx_reg <= idx_reg;
            end
        endcase
    end

    assign st.idx_end     = idx_reg >= fill_reg;
    assign st.plan_modify = p_modify;
    assign st.plan_fetch  = p_fetch;
    assign st.shift_done  = dst_reg == stop_reg;
    assign st.write_new   = newrec_reg;
    assign st.out_free    = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = {o_count_reg, o_gr_reg, o_hg_reg, o_key_reg, o_status_reg};

endmodule

// File: hw/rtl/sorted_key_table_with_argmax_top.sv
`timescale 1ns / 1ps
// Sorted key table with highest-grade tracking.
// Slave channel s_*: one command per transfer (opcode, key, grade flag, grade,
// 1-based position). Master channel m_*: exactly one result per command
// (status, record key, grade flag, grade, entry count after the command).
// Commands are handled one at a time. Every command first scans the filled
// part of the table through the single table RAM read port. Successful
// queries other than size then fetch one record. Changes move entries one
// at a time, then rescan for the best grade.
// Reset empties the table and clears the best-grade record; table RAM
// contents are not cleared and need no clearing pass.
// The result sits in an output register: the next command is accepted while
// it waits, and a stalled m_tready only holds the block at the end of that
// next command until the earlier result is taken.
module sorted_key_table_with_argmax_top
    import skt_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    // opcode[2:0], key[29:3], has_grade[30], grade[40:31], position[47:41]
    input  logic [DATA_W-1:0] s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    // status[2:0], out_key[29:3], out_has_grade[30], out_grade[40:31],
    // entry_count[47:41]
    output logic [DATA_W-1:0] m_tdata
);

    cmd_t       cmd;
    dp_status_t st;

    skt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    skt_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .in_data   (s_tdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

// File: hw/rtl/skt_checker.sv
`timescale 1ns / 1ps
`include "sorted_key_table_with_argmax_top_defines.svh"
module skt_checker
    import skt_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input logic              clk,
    input logic              rst_n,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [DATA_W-1:0] m_tdata
);

    // Stalled result holds
    `SKT_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed under stall")
    // One command at a time
    `SKT_ASSERT_NEXT(a_one, s_tvalid && s_tready, !s_tready, "command taken while busy")
    // Failed commands return no record
    `SKT_ASSERT_NOW(a_clean, m_tvalid && m_tdata[2:0] != ST_OK, m_tdata[40:3] == '0, "record on error")
    // Status code in range
    `SKT_ASSERT_NOW(a_stat, m_tvalid, m_tdata[2:0] <= ST_DUPLICATE, "bad status code")
    // Entry count within capacity
    `SKT_ASSERT_NOW(a_cnt, m_tvalid && CAPACITY < 128, 32'(m_tdata[47:41]) <= CAPACITY, "count too big")

endmodule

bind sorted_key_table_with_argmax_top skt_checker #(.CAPACITY(CAPACITY)) u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
